// ===== sv/dtthd_pkg.sv =====
// Shared types, codes and reset constants of the dual touch tap/hold detector.
`default_nettype none

package dtthd_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int CFG_WIDTH      = 16;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_WIDTH-1:0] HOLD_RESET     = 16'd1000;

  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_HOLD     = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_EDGE = 2'd1,
    CMD_POLL = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_DEBOUNCE = 2'd1,
    MODE_PRESSED  = 2'd2,
    MODE_RELEASED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_TAP    = 2'd0,
    KIND_HOLD   = 2'd1,
    KIND_DOUBLE = 2'd2
  } kind_t;

  typedef struct packed {
    cmd_t command;
    logic edge_side;
    logic left_level;
    logic right_level;
  } item_t;

  typedef struct packed {
    logic  event_valid;
    logic  event_side;
    kind_t event_kind;
  } result_t;

  typedef struct packed {
    logic                 wen;
    logic                 index;
    logic [CFG_WIDTH-1:0] wdata;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ===== sv/dtthd_core.sv =====
// Channel state, timer, configuration registers and per-request update logic.
`default_nettype none

module dtthd_core import dtthd_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_wr_t cfg,
  input  wire item_t   item,
  input  wire logic    fire,
  output result_t      res
);

  logic [CFG_WIDTH-1:0]  debounce_time;
  logic [CFG_WIDTH-1:0]  hold_time;
  logic [TIME_WIDTH-1:0] time_now;
  logic [TIME_WIDTH-1:0] time_now_next;
  mode_t                 mode [2];
  mode_t                 mode_next [2];
  logic [1:0]            pending;
  logic [1:0]            pending_next;
  kind_t                 pkind [2];
  kind_t                 pkind_next [2];
  logic [TIME_WIDTH-1:0] press_time [2];
  logic [TIME_WIDTH-1:0] press_time_next [2];
  logic [TIME_WIDTH-1:0] elapsed [2];
  logic [1:0]            ge_deb;
  logic [1:0]            ge_hold;
  logic [1:0]            level;
  logic                  both_pressed;

  assign level        = {item.right_level, item.left_level};
  assign both_pressed = (mode[0] == MODE_PRESSED) && (mode[1] == MODE_PRESSED);

  for (genvar g = 0; g < 2; g++) begin : g_cmp
    assign elapsed[g] = time_now - press_time[g];
    assign ge_deb[g]  = elapsed[g] >= TIME_WIDTH'(debounce_time);
    assign ge_hold[g] = elapsed[g] >= TIME_WIDTH'(hold_time);
  end

  always_comb begin
    res.event_valid = (item.command == CMD_POLL) && (pending != 2'b00);
    res.event_side  = !pending[0];
    res.event_kind  = pending[0] ? pkind[0] : pkind[1];
  end

  always_comb begin
    time_now_next = time_now;
    pending_next  = pending;
    for (int c = 0; c < 2; c++) begin
      mode_next[c]       = mode[c];
      pkind_next[c]      = pkind[c];
      press_time_next[c] = press_time[c];
    end
    if (fire) begin
      case (item.command)
        CMD_TICK: begin
          time_now_next = time_now + TIME_WIDTH'(1);
        end
        CMD_EDGE: begin
          if (mode[item.edge_side] == MODE_IDLE) begin
            mode_next[item.edge_side]       = MODE_DEBOUNCE;
            press_time_next[item.edge_side] = time_now;
          end else if (mode[item.edge_side] == MODE_DEBOUNCE && ge_deb[item.edge_side]) begin
            mode_next[item.edge_side]       = MODE_PRESSED;
            press_time_next[item.edge_side] = time_now;
          end
        end
        CMD_POLL: begin
          if (pending[0]) begin
            pending_next[0] = 1'b0;
          end else if (pending[1]) begin
            pending_next[1] = 1'b0;
          end else begin
            for (int c = 0; c < 2; c++) begin
              if (both_pressed) begin
                mode_next[c]    = MODE_RELEASED;
                pkind_next[c]   = KIND_DOUBLE;
                pending_next[c] = 1'b1;
              end
              if (mode_next[c] == MODE_PRESSED && ge_hold[c]) begin
                mode_next[c]    = MODE_RELEASED;
                pkind_next[c]   = KIND_HOLD;
                pending_next[c] = 1'b1;
              end
              if (mode_next[c] == MODE_PRESSED && !level[c]) begin
                if (ge_deb[c] && !ge_hold[c]) begin
                  pkind_next[c]   = KIND_TAP;
                  pending_next[c] = 1'b1;
                end
                mode_next[c] = MODE_RELEASED;
              end
              if (mode_next[c] == MODE_RELEASED && !pending_next[c]) begin
                mode_next[c] = MODE_IDLE;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= DEBOUNCE_RESET;
      hold_time     <= HOLD_RESET;
      time_now      <= '0;
      pending       <= 2'b00;
      mode[0]       <= MODE_IDLE;
      mode[1]       <= MODE_IDLE;
    end else begin
      if (cfg.wen && cfg.index == REG_DEBOUNCE) begin
        debounce_time <= cfg.wdata;
      end
      if (cfg.wen && cfg.index == REG_HOLD) begin
        hold_time <= cfg.wdata;
      end
      time_now <= time_now_next;
      pending  <= pending_next;
      mode[0]  <= mode_next[0];
      mode[1]  <= mode_next[1];
    end
  end

  always_ff @(posedge clk) begin
    pkind[0]      <= pkind_next[0];
    pkind[1]      <= pkind_next[1];
    press_time[0] <= press_time_next[0];
    press_time[1] <= press_time_next[1];
  end

`ifndef SYNTHESIS
  a_pending_left_released: assert property (@(posedge clk) disable iff (rst)
    pending[0] |-> mode[0] == MODE_RELEASED)
    else $error("left event pending outside released mode");

  a_pending_right_released: assert property (@(posedge clk) disable iff (rst)
    pending[1] |-> mode[1] == MODE_RELEASED)
    else $error("right event pending outside released mode");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    fire && item.command == CMD_TICK |=> time_now == $past(time_now) + TIME_WIDTH'(1))
    else $error("tick did not advance the timer");

  a_poll_drains_left: assert property (@(posedge clk) disable iff (rst)
    fire && item.command == CMD_POLL && pending[0] |=> !pending[0] && $stable(pending[1]))
    else $error("poll did not hand out the left event alone");
`endif

endmodule

`default_nettype wire

// ===== sv/dual_touch_tap_hold_detector.sv =====
// Top level: request register, channel logic and result register of the touch detector.
//
// Requests arrive on the s_ side: s_tuser carries the command (tick, edge or poll),
// s_tdata the channel of an edge and the two pin levels of a poll. A poll that hands
// out a pending event produces one result on the m_ side; every other request
// produces none. Registers debounce_time (index 0) and hold_time (index 1) are
// written through cfg_wen / cfg_index / cfg_wdata; the user must write them only
// while the block is idle, which the block itself does not enforce. A request is
// registered on acceptance and worked from the request register; a poll's result
// goes to the result register, which drives m_tvalid. One request is accepted per
// cycle unless a poll with an event waits on a stalled receiver. When the receiver
// stalls with a result waiting, requests that give no result still go through; a
// poll with an event to hand out waits in the request register and s_tready falls
// until the result register frees up. Reset clears both channels to idle, the timer
// to zero, all pending events and any waiting request; it restores register defaults.
`default_nettype none

module dual_touch_tap_hold_detector import dtthd_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // edge_side, left_level, right_level, zero fill
  input  wire logic [1:0]           s_tuser,   // command
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [7:0]                m_tdata,   // event_valid, event_side, zero fill
  output logic [1:0]                m_tuser,   // event_kind
  input  wire logic                 cfg_wen,
  input  wire logic                 cfg_index,
  input  wire logic [CFG_WIDTH-1:0] cfg_wdata
);

  logic    in_valid;
  item_t   in_item;
  result_t res;
  result_t out_res;
  logic    out_valid;
  logic    fire;
  cfg_wr_t cfg;

  assign cfg = '{wen: cfg_wen, index: cfg_index, wdata: cfg_wdata};

  assign fire     = in_valid && (!res.event_valid || !out_valid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.command     <= cmd_t'(s_tuser);
      in_item.edge_side   <= s_tdata[0];
      in_item.left_level  <= s_tdata[1];
      in_item.right_level <= s_tdata[2];
    end
  end

  dtthd_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (in_item),
    .fire (fire),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res.event_valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.event_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_res.event_side, out_res.event_valid};
  assign m_tuser  = out_res.event_kind;

endmodule

`default_nettype wire
